>>> rtl/hc3_pkg.sv
package hc3_pkg;

   localparam int Letters   = 26;
   localparam int GroupSize = 3;
   localparam int KeyRows   = 3;
   localparam int KeyCells  = KeyRows * GroupSize;
   localparam int RowWidth  = 15;

   typedef logic [4:0] letter_type;
   typedef logic [3:0] kidx_type;
   typedef logic [1:0] csr_idx_type;

   localparam letter_type PadLetter = 5'd25;
   localparam letter_type LastLetter = 5'd25;

   // Configuration register indexes.
   localparam csr_idx_type CsrKeyRow0 = 2'd0;
   localparam csr_idx_type CsrKeyRow1 = 2'd1;
   localparam csr_idx_type CsrKeyRow2 = 2'd2;

   typedef struct packed {
      logic       en;
      logic       clr;
      logic       neg;
      letter_type a;
      letter_type b;
   } mac_cmd_type;

   typedef struct packed {
      kidx_type a1;
      kidx_type b1;
      kidx_type a2;
      kidx_type b2;
   } cof_ops_type;

   function automatic letter_type reduce_letter(input logic [4:0] v);
      return (v >= 5'd26) ? v - 5'd26 : v;
   endfunction

   function automatic letter_type neg26(input letter_type v);
      return (v == 5'd0) ? 5'd0 : 5'd26 - v;
   endfunction

   // Reduces a value below 26*26 by conditional subtraction of 26 times 16, 8, 4, 2, 1.
   function automatic letter_type mod26_small(input logic [9:0] v);
      logic [9:0] r;
      r = v;
      if (r >= 10'd416) r = r - 10'd416;
      if (r >= 10'd208) r = r - 10'd208;
      if (r >= 10'd104) r = r - 10'd104;
      if (r >= 10'd52)  r = r - 10'd52;
      if (r >= 10'd26)  r = r - 10'd26;
      return r[4:0];
   endfunction

   // Cofactor n = 3*i+j is k[a1]*k[b1] - k[a2]*k[b2].
   function automatic cof_ops_type cof_ops(input kidx_type n);
      cof_ops_type o;
      case (n)
         4'd0:    o = '{4'd4, 4'd8, 4'd5, 4'd7};
         4'd1:    o = '{4'd5, 4'd6, 4'd3, 4'd8};
         4'd2:    o = '{4'd3, 4'd7, 4'd4, 4'd6};
         4'd3:    o = '{4'd2, 4'd7, 4'd1, 4'd8};
         4'd4:    o = '{4'd0, 4'd8, 4'd2, 4'd6};
         4'd5:    o = '{4'd1, 4'd6, 4'd0, 4'd7};
         4'd6:    o = '{4'd1, 4'd5, 4'd2, 4'd4};
         4'd7:    o = '{4'd2, 4'd3, 4'd0, 4'd5};
         4'd8:    o = '{4'd0, 4'd4, 4'd1, 4'd3};
         default: o = '{4'd0, 4'd0, 4'd0, 4'd0};
      endcase
      return o;
   endfunction

   function automatic kidx_type transpose_idx(input kidx_type n);
      kidx_type t;
      case (n)
         4'd0:    t = 4'd0;
         4'd1:    t = 4'd3;
         4'd2:    t = 4'd6;
         4'd3:    t = 4'd1;
         4'd4:    t = 4'd4;
         4'd5:    t = 4'd7;
         4'd6:    t = 4'd2;
         4'd7:    t = 4'd5;
         4'd8:    t = 4'd8;
         default: t = 4'd0;
      endcase
      return t;
   endfunction

endpackage

>>> rtl/hc3_mac.sv
module hc3_mac (
   input  logic                clock,
   input  hc3_pkg::mac_cmd_type cmd,
   output hc3_pkg::letter_type  sum
);
   import hc3_pkg::*;

   letter_type acc_ff;
   letter_type acc_in;
   letter_type b_eff;
   logic [9:0] prod;
   logic [9:0] total;

   always_comb begin
      b_eff  = cmd.neg ? neg26(cmd.b) : cmd.b;
      prod   = 10'(cmd.a) * 10'(b_eff);
      total  = prod + (cmd.clr ? 10'd0 : 10'(acc_ff));
      acc_in = mod26_small(total);
   end

   assign sum = acc_in;

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         acc_ff <= acc_in;
      end
   end

endmodule

>>> rtl/hc3_ctrl.sv
module hc3_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   key_write,
   input  hc3_pkg::letter_type [hc3_pkg::KeyCells-1:0] key_letters,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [4:0]                             req_cipher_letter,
   input  logic                                   req_message_end,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [4:0]                             rsp_plain_letter,
   output logic                                   rsp_group_last,
   output logic                                   rsp_message_last,
   output logic                                   rsp_key_invalid,
   output hc3_pkg::mac_cmd_type                   mac_cmd,
   input  hc3_pkg::letter_type                    mac_sum
);
   import hc3_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_COF  = 3'd1;
   localparam logic [2:0] ST_DET  = 3'd2;
   localparam logic [2:0] ST_SRCH = 3'd3;
   localparam logic [2:0] ST_INV  = 3'd4;
   localparam logic [2:0] ST_CALC = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  idx_ff, idx_in;
   logic [1:0]  sub_ff, sub_in;
   logic [1:0]  held_count_ff, held_count_in;
   letter_type  held_ff [2];
   letter_type  held_in [2];
   letter_type  item_letter_ff, item_letter_in;
   logic        item_end_ff, item_end_in;
   letter_type  cof_ff [KeyCells];
   letter_type  cof_in [KeyCells];
   letter_type  inv_ff [KeyCells];
   letter_type  inv_in [KeyCells];
   letter_type  det_ff, det_in;
   letter_type  dinv_ff, dinv_in;
   logic        inverse_ready_ff, inverse_ready_in;
   logic        key_bad_ff, key_bad_in;
   logic        rsp_valid_ff, rsp_valid_in;
   letter_type  rsp_plain_letter_ff, rsp_plain_letter_in;
   logic        rsp_group_last_ff, rsp_group_last_in;
   logic        rsp_message_last_ff, rsp_message_last_in;
   logic        rsp_key_invalid_ff, rsp_key_invalid_in;

   letter_type  in_letter;
   letter_type  p_sel;
   letter_type  p0, p1, p2;
   kidx_type    inv_idx;
   kidx_type    sub_idx;
   cof_ops_type ops;
   logic        out_free;
   logic        hold_item;
   logic [1:0]  col;

   always_comb begin
      state_in            = state_ff;
      idx_in              = idx_ff;
      sub_in              = sub_ff;
      held_count_in       = held_count_ff;
      held_in             = held_ff;
      item_letter_in      = item_letter_ff;
      item_end_in         = item_end_ff;
      cof_in              = cof_ff;
      inv_in              = inv_ff;
      det_in              = det_ff;
      dinv_in             = dinv_ff;
      inverse_ready_in    = inverse_ready_ff;
      key_bad_in          = key_bad_ff;
      rsp_valid_in        = rsp_valid_ff;
      rsp_plain_letter_in = rsp_plain_letter_ff;
      rsp_group_last_in   = rsp_group_last_ff;
      rsp_message_last_in = rsp_message_last_ff;
      rsp_key_invalid_in  = rsp_key_invalid_ff;
      mac_cmd             = '0;

      in_letter = reduce_letter(req_cipher_letter);
      out_free  = !rsp_valid_ff || rsp_ready;
      hold_item = (held_count_ff != 2'd2) && !item_end_ff;
      col       = idx_ff[1:0];
      sub_idx   = {2'b00, sub_ff};
      ops       = cof_ops(idx_ff[3:0]);
      inv_idx   = ({2'b00, sub_ff} << 1) + {2'b00, sub_ff} + {2'b00, col};

      // The group vector: held letters first, then the closing letter, then padding.
      p0 = (held_count_ff == 2'd0) ? item_letter_ff : held_ff[0];
      p1 = (held_count_ff == 2'd0) ? PadLetter :
           (held_count_ff == 2'd1) ? item_letter_ff : held_ff[1];
      p2 = (held_count_ff == 2'd2) ? item_letter_ff : PadLetter;
      case (sub_ff)
         2'd0:    p_sel = p0;
         2'd1:    p_sel = p1;
         default: p_sel = p2;
      endcase

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (key_write) begin
         inverse_ready_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (inverse_ready_ff && held_count_ff != 2'd2 && !req_message_end) begin
                  held_in[held_count_ff[0]] = in_letter;
                  held_count_in             = held_count_ff + 2'd1;
               end else begin
                  item_letter_in = in_letter;
                  item_end_in    = req_message_end;
                  idx_in         = 5'd0;
                  sub_in         = 2'd0;
                  state_in       = inverse_ready_ff ? ST_CALC : ST_COF;
               end
            end
         end
         ST_COF: begin
            mac_cmd.en = 1'b1;
            if (sub_ff == 2'd0) begin
               mac_cmd.clr = 1'b1;
               mac_cmd.a   = key_letters[ops.a1];
               mac_cmd.b   = key_letters[ops.b1];
               sub_in      = 2'd1;
            end else begin
               mac_cmd.neg           = 1'b1;
               mac_cmd.a             = key_letters[ops.a2];
               mac_cmd.b             = key_letters[ops.b2];
               cof_in[idx_ff[3:0]]   = mac_sum;
               sub_in                = 2'd0;
               if (idx_ff == 5'(KeyCells - 1)) begin
                  idx_in   = 5'd0;
                  state_in = ST_DET;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         ST_DET: begin
            mac_cmd.en  = 1'b1;
            mac_cmd.clr = (sub_ff == 2'd0);
            mac_cmd.a   = key_letters[sub_idx];
            mac_cmd.b   = cof_ff[sub_idx];
            if (sub_ff == 2'd2) begin
               det_in   = mac_sum;
               sub_in   = 2'd0;
               idx_in   = 5'd1;
               state_in = ST_SRCH;
            end else begin
               sub_in = sub_ff + 2'd1;
            end
         end
         ST_SRCH: begin
            // Trial multiplication of the determinant by each candidate inverse.
            mac_cmd.en  = 1'b1;
            mac_cmd.clr = 1'b1;
            mac_cmd.a   = det_ff;
            mac_cmd.b   = idx_ff;
            if (mac_sum == 5'd1) begin
               dinv_in    = idx_ff;
               key_bad_in = 1'b0;
               idx_in     = 5'd0;
               state_in   = ST_INV;
            end else if (idx_ff == LastLetter) begin
               dinv_in    = 5'd0;
               key_bad_in = 1'b1;
               idx_in     = 5'd0;
               state_in   = ST_INV;
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         ST_INV: begin
            mac_cmd.en          = 1'b1;
            mac_cmd.clr         = 1'b1;
            mac_cmd.a           = dinv_ff;
            mac_cmd.b           = cof_ff[transpose_idx(idx_ff[3:0])];
            inv_in[idx_ff[3:0]] = mac_sum;
            if (idx_ff == 5'(KeyCells - 1)) begin
               inverse_ready_in = 1'b1;
               idx_in           = 5'd0;
               sub_in           = 2'd0;
               if (hold_item) begin
                  held_in[held_count_ff[0]] = item_letter_ff;
                  held_count_in             = held_count_ff + 2'd1;
                  state_in                  = ST_IDLE;
               end else begin
                  state_in = ST_CALC;
               end
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         ST_CALC: begin
            mac_cmd.clr = (sub_ff == 2'd0);
            mac_cmd.a   = p_sel;
            mac_cmd.b   = inv_ff[inv_idx];
            if (sub_ff == 2'd2) begin
               // The last product of a column waits here until the output word is free.
               if (out_free) begin
                  mac_cmd.en          = 1'b1;
                  rsp_valid_in        = 1'b1;
                  rsp_plain_letter_in = key_bad_ff ? 5'd0 : mac_sum;
                  rsp_group_last_in   = (col == 2'd2);
                  rsp_message_last_in = (col == 2'd2) && item_end_ff;
                  rsp_key_invalid_in  = key_bad_ff;
                  sub_in              = 2'd0;
                  if (col == 2'd2) begin
                     held_count_in = 2'd0;
                     idx_in        = 5'd0;
                     state_in      = ST_IDLE;
                  end else begin
                     idx_in = idx_ff + 5'd1;
                  end
               end
            end else begin
               mac_cmd.en = 1'b1;
               sub_in     = sub_ff + 2'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         held_count_ff    <= 2'd0;
         inverse_ready_ff <= 1'b0;
         key_bad_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         held_count_ff    <= held_count_in;
         inverse_ready_ff <= inverse_ready_in;
         key_bad_ff       <= key_bad_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff              <= idx_in;
      sub_ff              <= sub_in;
      held_ff             <= held_in;
      item_letter_ff      <= item_letter_in;
      item_end_ff         <= item_end_in;
      cof_ff              <= cof_in;
      inv_ff              <= inv_in;
      det_ff              <= det_in;
      dinv_ff             <= dinv_in;
      rsp_plain_letter_ff <= rsp_plain_letter_in;
      rsp_group_last_ff   <= rsp_group_last_in;
      rsp_message_last_ff <= rsp_message_last_in;
      rsp_key_invalid_ff  <= rsp_key_invalid_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_plain_letter = rsp_plain_letter_ff;
   assign rsp_group_last   = rsp_group_last_ff;
   assign rsp_message_last = rsp_message_last_ff;
   assign rsp_key_invalid  = rsp_key_invalid_ff;

`ifndef ASSERT_OFF
   a_bad_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_key_invalid_ff |-> rsp_plain_letter_ff == 5'd0)
      else $error("word with invalid key carries a nonzero letter");

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd3)
      else $error("held letter count overflowed");

   a_msg_on_group_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_message_last_ff |-> rsp_group_last_ff)
      else $error("message end flagged away from a group end");

   a_calc_needs_inverse: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CALC |-> inverse_ready_ff)
      else $error("decrypting without a derived inverse key");

   a_group_clears_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CALC && state_in == ST_IDLE |=> held_count_ff == 2'd0)
      else $error("held count not cleared after a group");
`endif

endmodule

>>> rtl/hill_cipher_3x3_decrypt.sv
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_ready    req_cipher_letter, req_message_end
// rsp       out        rsp_valid / rsp_ready    rsp_plain_letter, rsp_group_last,
//                                               rsp_message_last, rsp_key_invalid
// csr       in         csr_wr_en (no wait)      csr_index, csr_wdata
//
// A letter that only joins a group is held until the group closes. A letter that closes a group
// is accepted and then takes nine passes of the shared mod-26 multiply-accumulate unit, three
// per output word; the output side can stall the last pass of each word.
// The first letter after reset or a key write also pays for the inverse-key derivation on
// the same unit: cofactors, determinant, a search for the inverse of the determinant, adjugate.
// Reset is synchronous and active high; a stalled output word stalls the unit, not the key.
module hill_cipher_3x3_decrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_cipher_letter,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_plain_letter,
   output logic        rsp_group_last,
   output logic        rsp_message_last,
   output logic        rsp_key_invalid,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);
   import hc3_pkg::*;

   logic [RowWidth-1:0]       key_row_ff [KeyRows];
   logic [RowWidth-1:0]       key_row_in [KeyRows];
   letter_type [KeyCells-1:0] key_letters;
   logic                      key_write;
   mac_cmd_type               mac_cmd;
   letter_type                mac_sum;

   always_comb begin
      key_row_in = key_row_ff;
      key_write  = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            CsrKeyRow0: begin
               key_row_in[0] = csr_wdata;
               key_write     = 1'b1;
            end
            CsrKeyRow1: begin
               key_row_in[1] = csr_wdata;
               key_write     = 1'b1;
            end
            CsrKeyRow2: begin
               key_row_in[2] = csr_wdata;
               key_write     = 1'b1;
            end
            default: begin
               key_write = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < KeyRows; r++) begin
            key_row_ff[r] <= '0;
         end
      end else begin
         key_row_ff <= key_row_in;
      end
   end

   always_comb begin
      for (int r = 0; r < KeyRows; r++) begin
         for (int c = 0; c < GroupSize; c++) begin
            key_letters[r * GroupSize + c] = reduce_letter(key_row_ff[r][5 * c +: 5]);
         end
      end
   end

   hc3_mac u_mac (
      .clock (clock),
      .cmd   (mac_cmd),
      .sum   (mac_sum)
   );

   hc3_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .key_write         (key_write),
      .key_letters       (key_letters),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cipher_letter (req_cipher_letter),
      .req_message_end   (req_message_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_plain_letter  (rsp_plain_letter),
      .rsp_group_last    (rsp_group_last),
      .rsp_message_last  (rsp_message_last),
      .rsp_key_invalid   (rsp_key_invalid),
      .mac_cmd           (mac_cmd),
      .mac_sum           (mac_sum)
   );

endmodule
